// File: hdl/i2c_rtc_register_slave_assert.svh
// Assertion macros for the I2C RTC register slave.
`ifndef I2C_RTC_REGISTER_SLAVE_ASSERT_SVH
`define I2C_RTC_REGISTER_SLAVE_ASSERT_SVH

// Check a consequent in the same cycle as its antecedent.
`define I2CRTC_ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Check a consequent in the cycle after its antecedent.
`define I2CRTC_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: hdl/i2crtc_pkg.sv
// Shared types and constants of the I2C RTC register slave.
package i2crtc_pkg;

	localparam int TIME_REGS     = 16;
	localparam int RAM_BYTES_DEF = 240;
	localparam logic [6:0] ADDR_RESET = 7'h50;
	localparam logic [7:0] REG_CTRL   = 8'd0;
	localparam logic [7:0] REG_RO_A   = 8'd1;
	localparam logic [7:0] REG_RO_B   = 8'd7;
	localparam int HALT_BIT = 7;

	typedef enum logic [3:0] {
		PH_IDLE,
		PH_ADDR,
		PH_ADDR_WACK,
		PH_ADDR_RACK,
		PH_PTR,
		PH_PTR_ACK,
		PH_WRITE,
		PH_WRITE_ACK,
		PH_READ,
		PH_READ_ACK
	} phase_t;

	typedef struct packed {
		logic       en;
		logic [7:0] addr;
		logic [7:0] data;
	} wr_req_t;

	typedef struct packed {
		logic       en;
		logic [7:0] addr;
	} rd_req_t;

	typedef struct packed {
		phase_t     phase;
		logic [3:0] bit_cnt;
		logic       use_fetch;
		logic [7:0] shift;
	} stat_t;

endpackage

// File: hdl/i2crtc_store.sv
// Clock register bank, read snapshot and user RAM with registered fetch.
module i2crtc_store #(
	parameter int RAM_BYTES = i2crtc_pkg::RAM_BYTES_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  i2crtc_pkg::wr_req_t  wr,
	input  i2crtc_pkg::rd_req_t  rd,
	input  logic                 snap,
	output logic [7:0]           fetch_data,
	output logic                 halt
);

	localparam int CAW    = $clog2(i2crtc_pkg::TIME_REGS);
	localparam int RAM_AW = $clog2(RAM_BYTES);

	logic [7:0] bank_q [i2crtc_pkg::TIME_REGS];
	logic [7:0] copy_q [i2crtc_pkg::TIME_REGS];
	logic [7:0] ram_q  [RAM_BYTES];
	logic [RAM_BYTES-1:0] ram_vld_q;

	logic [7:0] copy_byte_q;
	logic [7:0] ram_rd_q;
	logic       copy_hit_q;
	logic       ram_hit_q;
	logic       halt_q;

	logic [7:0]        wr_off;
	logic [7:0]        rd_off;
	logic [RAM_AW-1:0] wr_idx;
	logic [RAM_AW-1:0] rd_idx;
	logic              wr_bank;
	logic              wr_ram;
	logic              rd_bank;
	logic              rd_ram;

	assign wr_off  = wr.addr - 8'(i2crtc_pkg::TIME_REGS);
	assign rd_off  = rd.addr - 8'(i2crtc_pkg::TIME_REGS);
	assign wr_idx  = wr_off[RAM_AW-1:0];
	assign rd_idx  = rd_off[RAM_AW-1:0];
	assign wr_bank = wr.addr < 8'(i2crtc_pkg::TIME_REGS);
	assign rd_bank = rd.addr < 8'(i2crtc_pkg::TIME_REGS);
	assign wr_ram  = !wr_bank && (wr_off < 8'(RAM_BYTES));
	assign rd_ram  = !rd_bank && (rd_off < 8'(RAM_BYTES));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < i2crtc_pkg::TIME_REGS; i++) begin
				bank_q[i] <= 8'd0;
				copy_q[i] <= 8'd0;
			end
			halt_q <= 1'b0;
		end else begin
			if (wr.en && wr_bank && wr.addr != i2crtc_pkg::REG_RO_A &&
				wr.addr != i2crtc_pkg::REG_RO_B) begin
				bank_q[wr.addr[CAW-1:0]] <= wr.data;
				if (wr.addr == i2crtc_pkg::REG_CTRL) begin
					halt_q <= wr.data[i2crtc_pkg::HALT_BIT];
				end
			end
			if (snap) begin
				for (int i = 0; i < i2crtc_pkg::TIME_REGS; i++) begin
					copy_q[i] <= (8'(i) == i2crtc_pkg::REG_RO_B) ? 8'd0 : bank_q[i];
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ram_vld_q  <= '0;
			copy_hit_q <= 1'b0;
			ram_hit_q  <= 1'b0;
		end else begin
			if (wr.en && wr_ram) begin
				ram_vld_q[wr_idx] <= 1'b1;
			end
			if (rd.en) begin
				copy_hit_q <= rd_bank;
				ram_hit_q  <= rd_ram && ram_vld_q[rd_idx];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (wr.en && wr_ram) begin
			ram_q[wr_idx] <= wr.data;
		end
		if (rd.en && rd_ram) begin
			ram_rd_q <= ram_q[rd_idx];
		end
		if (rd.en && rd_bank) begin
			copy_byte_q <= copy_q[rd.addr[CAW-1:0]];
		end
	end

	assign fetch_data = copy_hit_q ? copy_byte_q : (ram_hit_q ? ram_rd_q : 8'd0);
	assign halt       = halt_q;

endmodule

// File: hdl/i2crtc_ctrl.sv
// Bus state machine: line levels, start and stop detection, byte shifting, pointer.
module i2crtc_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 ev,
	input  logic                 req_type,
	input  logic                 line_level,
	input  logic [6:0]           slave_address,
	output i2crtc_pkg::wr_req_t  wr,
	output i2crtc_pkg::rd_req_t  rd,
	output logic                 snap,
	output i2crtc_pkg::stat_t    stat
);

	i2crtc_pkg::phase_t phase_q, phase_d;
	logic [7:0] shift_q, shift_d;
	logic [3:0] bit_cnt_q, bit_cnt_d;
	logic [7:0] ptr_q, ptr_d;
	logic       use_fetch_q, use_fetch_d;
	logic       scl_q, scl_d;
	logic       sda_q, sda_d;

	logic       scl_rise;
	logic       sda_chg;
	logic       start;
	logic       stop;
	logic [7:0] wbyte;
	logic [7:0] shifted;
	logic [3:0] cnt_inc;
	logic       done;

	assign scl_rise = ev && !req_type && line_level && !scl_q;
	assign sda_chg  = ev && req_type && (line_level != sda_q);
	assign start    = sda_chg && scl_q && !line_level;
	assign stop     = sda_chg && scl_q && line_level;
	assign wbyte    = {slave_address, 1'b0};
	assign shifted  = shift_q | (8'({7'd0, sda_q}) << (3'd7 - bit_cnt_q[2:0]));
	assign cnt_inc  = bit_cnt_q + 4'd1;
	assign done     = cnt_inc[3];

	always_comb begin
		phase_d     = phase_q;
		shift_d     = shift_q;
		bit_cnt_d   = bit_cnt_q;
		ptr_d       = ptr_q;
		use_fetch_d = use_fetch_q;
		scl_d       = scl_q;
		sda_d       = sda_q;
		if (ev && !req_type) begin
			scl_d = line_level;
		end
		if (ev && req_type) begin
			sda_d = line_level;
		end
		if (scl_rise) begin
			case (phase_q)
				i2crtc_pkg::PH_ADDR: begin
					shift_d     = shifted;
					bit_cnt_d   = cnt_inc;
					use_fetch_d = 1'b0;
					if (done) begin
						if (shifted == wbyte) begin
							phase_d = i2crtc_pkg::PH_ADDR_WACK;
						end else if (shifted == (wbyte | 8'd1)) begin
							phase_d = i2crtc_pkg::PH_ADDR_RACK;
						end else begin
							phase_d = i2crtc_pkg::PH_IDLE;
						end
					end
				end
				i2crtc_pkg::PH_PTR: begin
					shift_d     = shifted;
					bit_cnt_d   = cnt_inc;
					use_fetch_d = 1'b0;
					if (done) begin
						phase_d = i2crtc_pkg::PH_PTR_ACK;
						ptr_d   = shifted;
					end
				end
				i2crtc_pkg::PH_WRITE: begin
					shift_d     = shifted;
					bit_cnt_d   = cnt_inc;
					use_fetch_d = 1'b0;
					if (done) begin
						phase_d = i2crtc_pkg::PH_WRITE_ACK;
						ptr_d   = ptr_q + 8'd1;
					end
				end
				i2crtc_pkg::PH_READ: begin
					bit_cnt_d = cnt_inc;
					if (done) begin
						phase_d = i2crtc_pkg::PH_READ_ACK;
					end
				end
				i2crtc_pkg::PH_READ_ACK: begin
					if (!sda_q) begin
						phase_d     = i2crtc_pkg::PH_READ;
						bit_cnt_d   = 4'd0;
						ptr_d       = ptr_q + 8'd1;
						use_fetch_d = 1'b1;
					end else begin
						phase_d = i2crtc_pkg::PH_IDLE;
					end
				end
				i2crtc_pkg::PH_ADDR_RACK: begin
					phase_d     = i2crtc_pkg::PH_READ;
					bit_cnt_d   = 4'd0;
					use_fetch_d = 1'b1;
				end
				i2crtc_pkg::PH_PTR_ACK, i2crtc_pkg::PH_WRITE_ACK: begin
					phase_d     = i2crtc_pkg::PH_WRITE;
					shift_d     = 8'd0;
					bit_cnt_d   = 4'd0;
					use_fetch_d = 1'b0;
				end
				i2crtc_pkg::PH_ADDR_WACK: begin
					phase_d     = i2crtc_pkg::PH_PTR;
					shift_d     = 8'd0;
					bit_cnt_d   = 4'd0;
					use_fetch_d = 1'b0;
				end
				default: begin
					phase_d = phase_q;
				end
			endcase
		end
		if (start) begin
			phase_d     = i2crtc_pkg::PH_ADDR;
			shift_d     = 8'd0;
			bit_cnt_d   = 4'd0;
			use_fetch_d = 1'b0;
		end else if (stop) begin
			phase_d = i2crtc_pkg::PH_IDLE;
		end
	end

	always_comb begin
		wr.en   = scl_rise && (phase_q == i2crtc_pkg::PH_WRITE) && done;
		wr.addr = ptr_q;
		wr.data = shifted;
		rd.en   = scl_rise && ((phase_q == i2crtc_pkg::PH_ADDR_RACK) ||
			((phase_q == i2crtc_pkg::PH_READ_ACK) && !sda_q));
		rd.addr = (phase_q == i2crtc_pkg::PH_READ_ACK) ? ptr_q + 8'd1 : ptr_q;
		snap    = start;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= i2crtc_pkg::PH_IDLE;
			shift_q     <= 8'd0;
			bit_cnt_q   <= 4'd0;
			ptr_q       <= 8'd0;
			use_fetch_q <= 1'b0;
			scl_q       <= 1'b1;
			sda_q       <= 1'b1;
		end else begin
			phase_q     <= phase_d;
			shift_q     <= shift_d;
			bit_cnt_q   <= bit_cnt_d;
			ptr_q       <= ptr_d;
			use_fetch_q <= use_fetch_d;
			scl_q       <= scl_d;
			sda_q       <= sda_d;
		end
	end

	assign stat.phase     = phase_q;
	assign stat.bit_cnt   = bit_cnt_q;
	assign stat.use_fetch = use_fetch_q;
	assign stat.shift     = shift_q;

endmodule

// File: hdl/i2c_rtc_register_slave.sv
// Top level of the I2C RTC register slave: handshake pipeline and SDA drive output.
//
// Input channel (in_valid/in_ready) carries one bus line event: req_type selects
// SCL (0) or SDA (1), line_level is the new level of that line.
// Output channel (out_valid/out_ready) returns one result per event: sda_drive is
// the level the slave drives on SDA afterwards (1 = released), clock_halted is
// the halt flag from bit 7 of the control register.
// cfg_wr_en/cfg_wr_data set the 7-bit bus address; the user must write it only
// while idle; the block itself does no check. Pipeline: input register, state
// update with registered memory fetch, result register. One event per cycle is
// taken in steady state while out_ready is high.
// The user RAM is one write port and one registered read port; its entries read
// as zero until first written, tracked by a valid bit per entry.
// Reset clears the bus state, the clock registers, the halt flag and all valid
// bits, and sets the address to 0x50. When out_ready is low the result holds and
// up to two more events are taken before in_ready drops.
module i2c_rtc_register_slave #(
	parameter int RAM_BYTES = i2crtc_pkg::RAM_BYTES_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic       req_type,
	input  logic       line_level,
	output logic       out_valid,
	input  logic       out_ready,
	output logic       sda_drive,
	output logic       clock_halted,
	input  logic       cfg_wr_en,
	input  logic [6:0] cfg_wr_data
);

	`include "i2c_rtc_register_slave_assert.svh"

	logic [6:0] slave_addr_q;
	logic       valid_s1;
	logic       req_s1;
	logic       lvl_s1;
	logic       valid_s2;
	logic       out_valid_q;
	logic       sda_drive_q;
	logic       halt_out_q;

	logic       out_adv;
	logic       s1_go;
	logic       s2_adv;
	logic       ev;
	logic       drive;
	logic [7:0] byte_eff;
	logic [7:0] fetch_data;
	logic       halt;

	i2crtc_pkg::wr_req_t wr_req;
	i2crtc_pkg::rd_req_t rd_req;
	i2crtc_pkg::stat_t   stat;
	logic                snap;

	assign out_adv  = !out_valid_q || out_ready;
	assign s1_go    = !valid_s2 || out_adv;
	assign s2_adv   = valid_s2 && out_adv;
	assign ev       = valid_s1 && s1_go;
	assign in_ready = !valid_s1 || s1_go;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slave_addr_q <= i2crtc_pkg::ADDR_RESET;
			valid_s1     <= 1'b0;
			valid_s2     <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				slave_addr_q <= cfg_wr_data;
			end
			if (in_ready) begin
				valid_s1 <= in_valid;
			end
			if (s1_go) begin
				valid_s2 <= valid_s1;
			end
			if (out_adv) begin
				out_valid_q <= valid_s2;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			req_s1 <= req_type;
			lvl_s1 <= line_level;
		end
		if (s2_adv) begin
			sda_drive_q <= drive;
			halt_out_q  <= halt;
		end
	end

	i2crtc_ctrl u_ctrl (
		.clk           (clk),
		.arst_n        (arst_n),
		.ev            (ev),
		.req_type      (req_s1),
		.line_level    (lvl_s1),
		.slave_address (slave_addr_q),
		.wr            (wr_req),
		.rd            (rd_req),
		.snap          (snap),
		.stat          (stat)
	);

	i2crtc_store #(
		.RAM_BYTES (RAM_BYTES)
	) u_store (
		.clk        (clk),
		.arst_n     (arst_n),
		.wr         (wr_req),
		.rd         (rd_req),
		.snap       (snap),
		.fetch_data (fetch_data),
		.halt       (halt)
	);

	assign byte_eff = stat.use_fetch ? fetch_data : stat.shift;

	always_comb begin
		case (stat.phase) inside
			i2crtc_pkg::PH_READ: begin
				drive = byte_eff[3'd7 - stat.bit_cnt[2:0]];
			end
			i2crtc_pkg::PH_ADDR_WACK, i2crtc_pkg::PH_ADDR_RACK, i2crtc_pkg::PH_PTR_ACK,
			i2crtc_pkg::PH_WRITE_ACK, i2crtc_pkg::PH_READ_ACK: begin
				drive = 1'b0;
			end
			default: begin
				drive = 1'b1;
			end
		endcase
	end

	assign out_valid    = out_valid_q;
	assign sda_drive    = sda_drive_q;
	assign clock_halted = halt_out_q;

	`I2CRTC_ASSERT_SAME(a_store_in_write, wr_req.en, (stat.phase == i2crtc_pkg::PH_WRITE) && (stat.bit_cnt == 4'd7), "store outside write byte end")
	`I2CRTC_ASSERT_NEXT(a_fetch_to_read, rd_req.en, (stat.phase == i2crtc_pkg::PH_READ) && stat.use_fetch, "fetch not followed by read phase")
	`I2CRTC_ASSERT_NEXT(a_start_addr, snap, (stat.phase == i2crtc_pkg::PH_ADDR) && (stat.bit_cnt == 4'd0), "start not followed by address phase")
	`I2CRTC_ASSERT_NEXT(a_out_hold, out_valid_q && !out_ready, out_valid_q && $stable(sda_drive_q) && $stable(halt_out_q), "stalled result changed")

endmodule
